// File: src/jaec_pkg.sv
// package for the json array element counter
// byte codes, byte class struct and the byte decoder; no dependencies
`timescale 1ns / 1ps

package jaec_pkg;

    localparam int COUNT_W = 16;

    localparam logic [7:0] WS_MAX      = 8'd32;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;

    typedef struct packed {
        logic is_ws;
        logic is_lbracket;
        logic is_rbracket;
        logic is_open;
        logic is_close;
        logic is_comma;
        logic is_quote;
        logic is_bslash;
    } byte_class_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        c.is_ws       = (b <= WS_MAX);
        c.is_lbracket = (b == CH_LBRACKET);
        c.is_rbracket = (b == CH_RBRACKET);
        c.is_open     = (b == CH_LBRACKET) || (b == CH_LBRACE);
        c.is_close    = (b == CH_RBRACKET) || (b == CH_RBRACE);
        c.is_comma    = (b == CH_COMMA);
        c.is_quote    = (b == CH_QUOTE);
        c.is_bslash   = (b == CH_BSLASH);
        return c;
    endfunction

endpackage

// File: src/json_array_element_counter.sv
// top level of the json array element counter: bracket framing and result register
// depends on jaec_pkg and jaec_scan
`timescale 1ns / 1ps

// Takes one byte of a JSON array text per beat on the slave side, with tlast on the
// final byte, and returns one beat on the master side per text: the number of
// top-level elements (0 when the text does not open with '[' and close with ']'
// after whitespace is skipped, or when the array is empty) and a flag that is set
// when a comma or a nesting level was dropped at its counter limit. A byte is taken every
// cycle unless the input stalls; the result appears in the cycle after the final byte is
// taken. The per-byte state update (string, depth and comma tally) is combinational and
// registered with each byte taken, which is what fixes the one-byte-per-cycle rate. The
// input stalls only while a finished result waits in the output register and the master side is not ready.
module json_array_element_counter #(
    parameter int COUNT_BITS = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] element_count
    output logic [0:0]  m_tuser     // [0] saturated
);

    jaec_pkg::byte_class_t cls;
    logic                  step;
    logic                  scan_en;
    logic [15:0]           count_next;
    logic                  hit_next;

    logic       seen_reg, seen_next;
    logic       opened_reg, opened_next;
    logic       close_reg, close_next;
    logic [1:0] inner_reg, inner_next;
    logic       frame_ok;

    logic        m_valid_reg;
    logic [15:0] m_count_reg;
    logic        m_sat_reg;

    assign cls      = jaec_pkg::classify(s_tdata);
    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign scan_en  = seen_reg && opened_reg;

    jaec_scan #(
        .COUNT_BITS (COUNT_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .clear      (s_tlast),
        .scan_en    (scan_en),
        .cls        (cls),
        .count_next (count_next),
        .hit_next   (hit_next)
    );

    // framing: first non-space byte must open, last non-space byte must close
    always_comb
    begin
        seen_next   = seen_reg;
        opened_next = opened_reg;
        close_next  = close_reg;
        inner_next  = inner_reg;
        if (!cls.is_ws)
        begin
            close_next = cls.is_rbracket;
            if (!seen_reg)
            begin
                seen_next   = 1'b1;
                opened_next = cls.is_lbracket;
            end
            else if (inner_reg != 2'd2)
            begin
                inner_next = inner_reg + 2'd1;
            end
        end
        frame_ok = opened_next && close_next && (inner_next == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            opened_reg <= 1'b0;
            close_reg  <= 1'b0;
            inner_reg  <= 2'd0;
        end
        else if (step)
        begin
            if (s_tlast)
            begin
                seen_reg   <= 1'b0;
                opened_reg <= 1'b0;
                close_reg  <= 1'b0;
                inner_reg  <= 2'd0;
            end
            else
            begin
                seen_reg   <= seen_next;
                opened_reg <= opened_next;
                close_reg  <= close_next;
                inner_reg  <= inner_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (step && s_tlast)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && s_tlast)
        begin
            m_count_reg <= frame_ok ? count_next : 16'd0;
            m_sat_reg   <= hit_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_count_reg;
    assign m_tuser[0] = m_sat_reg;

    // a final byte always leaves a result beat behind
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (step && s_tlast) |=> m_valid_reg)
        else $error("final byte did not load a result");

    // framing state starts over after the final byte
    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (step && s_tlast) |=> (!seen_reg && !opened_reg && inner_reg == 2'd0))
        else $error("framing state not cleared after final byte");

    // input is only held off while a result is waiting
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with an empty output register");

    // the open flag and inner count only exist after a non-space byte
    a_seen_first: assert property (@(posedge clk) disable iff (!rst_n)
        (opened_reg || inner_reg != 2'd0) |-> seen_reg)
        else $error("framing flags set before any non-space byte");

    // inner count saturates at two
    a_inner_range: assert property (@(posedge clk) disable iff (!rst_n)
        inner_reg != 2'd3)
        else $error("inner non-space count out of range");

endmodule

// File: src/jaec_scan.sv
// scanner for the array body: string state, nesting depth, top-level comma tally
// depends on jaec_pkg
`timescale 1ns / 1ps

module jaec_scan #(
    parameter int COUNT_BITS = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         clear,
    input  logic                         scan_en,
    input  jaec_pkg::byte_class_t        cls,
    output logic [jaec_pkg::COUNT_W-1:0] count_next,
    output logic                         hit_next
);

    // the tally never needs more than 16 bits since the count limit is 65535
    localparam int TALLY_W = (COUNT_BITS > jaec_pkg::COUNT_W) ? jaec_pkg::COUNT_W : COUNT_BITS;
    localparam logic [TALLY_W-1:0]    TALLY_MAX = {{(TALLY_W-1){1'b1}}, 1'b0};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  in_str_reg, in_str_next;
    logic                  bslash_reg, bslash_next;
    logic [TALLY_W-1:0]    tally_reg, tally_next;
    logic                  hit_reg;

    always_comb
    begin
        depth_next  = depth_reg;
        in_str_next = in_str_reg;
        tally_next  = tally_reg;
        hit_next    = hit_reg;
        bslash_next = cls.is_bslash;
        if (scan_en)
        begin
            if (cls.is_quote && !bslash_reg)
            begin
                in_str_next = !in_str_reg;
            end
            else if (!in_str_reg)
            begin
                if (cls.is_open)
                begin
                    if (depth_reg != DEPTH_MAX)
                        depth_next = depth_reg + 1'b1;
                    else
                        hit_next = 1'b1;
                end
                else if (cls.is_close)
                begin
                    if (depth_reg != '0)
                        depth_next = depth_reg - 1'b1;
                end
                else if (cls.is_comma && depth_reg == '0)
                begin
                    if (tally_reg < TALLY_MAX)
                        tally_next = tally_reg + 1'b1;
                    else
                        hit_next = 1'b1;
                end
            end
        end
        count_next = jaec_pkg::COUNT_W'(tally_next) + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            in_str_reg <= 1'b0;
            bslash_reg <= 1'b0;
            tally_reg  <= '0;
            hit_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (clear)
            begin
                depth_reg  <= '0;
                in_str_reg <= 1'b0;
                bslash_reg <= 1'b0;
                tally_reg  <= '0;
                hit_reg    <= 1'b0;
            end
            else
            begin
                depth_reg  <= depth_next;
                in_str_reg <= in_str_next;
                bslash_reg <= bslash_next;
                tally_reg  <= tally_next;
                hit_reg    <= hit_next;
            end
        end
    end

endmodule
